[hdl/wfhp_pkg.sv]
// Shared types and constants for the WebSocket frame header parser.
// Used by wfhp_front, wfhp_queue, wfhp_back and the top level; no dependencies.
package wfhp_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_EXTLEN,
      PH_KEY
   } phase_type;

   typedef struct packed {
      phase_type  op;
      logic [7:0] data;
      logic       last;
   } qent_type;

endpackage

[hdl/wfhp_front.sv]
// Front end: accepts header words, tracks the parse phase and tags each word.
// Depends on wfhp_pkg; feeds wfhp_queue.
module wfhp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_restart,
   output logic              push_valid,
   output wfhp_pkg::qent_type push_ent,
   input  logic              push_full
);
   import wfhp_pkg::*;

   phase_type  phase_ff, phase_in, cur_phase;
   logic [3:0] cnt_ff, cnt_in, cnt_inc;
   logic       long_ff, long_in;
   logic       mask_ff, mask_in;
   logic       accept;
   logic       done;
   logic       last;

   assign req_stall = push_full;
   assign accept    = req_valid && !push_full;
   assign cur_phase = req_restart ? PH_FIRST : phase_ff;
   assign cnt_inc   = cnt_ff + 4'd1;

   // next state
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      long_in  = long_ff;
      mask_in  = mask_ff;
      done     = 1'b0;
      if (accept) begin
         unique case (cur_phase)
            PH_FIRST: begin
               phase_in = PH_SECOND;
               cnt_in   = 4'd0;
            end
            PH_SECOND: begin
               cnt_in  = 4'd0;
               mask_in = req_data_byte[7];
               long_in = req_data_byte[0];
               if (req_data_byte[6:0] == LEN_CODE_16 || req_data_byte[6:0] == LEN_CODE_64) begin
                  phase_in = PH_EXTLEN;
               end else if (req_data_byte[7]) begin
                  phase_in = PH_KEY;
               end else begin
                  phase_in = PH_FIRST;
               end
            end
            PH_EXTLEN: begin
               done = (cnt_inc == (long_ff ? EXT64_BYTES : EXT16_BYTES));
               if (done) begin
                  cnt_in   = 4'd0;
                  phase_in = mask_ff ? PH_KEY : PH_FIRST;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            PH_KEY: begin
               done = (cnt_inc == KEY_BYTES);
               if (done) begin
                  cnt_in   = 4'd0;
                  phase_in = PH_FIRST;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      last = 1'b0;
      unique case (cur_phase)
         PH_FIRST:  last = 1'b0;
         PH_SECOND: last = !req_data_byte[7] && (req_data_byte[6:1] != 6'h3F);
         PH_EXTLEN: last = done && !mask_ff;
         PH_KEY:    last = done;
         default:   last = 1'b0;
      endcase
      push_valid    = req_valid;
      push_ent.op   = cur_phase;
      push_ent.data = req_data_byte;
      push_ent.last = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         cnt_ff   <= 4'd0;
         long_ff  <= 1'b0;
         mask_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         long_ff  <= long_in;
         mask_ff  <= mask_in;
      end
   end

endmodule

[hdl/wfhp_queue.sv]
// Short FIFO of tagged header words between front and back end.
// Depends on wfhp_pkg.
module wfhp_queue #(
   parameter int DEPTH = wfhp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  wfhp_pkg::qent_type push_ent,
   output logic               push_full,
   output logic               pop_valid,
   output wfhp_pkg::qent_type pop_ent,
   input  logic               pop
);
   import wfhp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   qent_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_full = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_ent   = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/wfhp_back.sv]
// Back end: assembles header fields from tagged words and holds the result.
// Depends on wfhp_pkg; drains wfhp_queue.
module wfhp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  wfhp_pkg::qent_type pop_ent,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_fin,
   output logic               rsp_rsv1,
   output logic               rsp_rsv2,
   output logic               rsp_rsv3,
   output logic [3:0]         rsp_frame_opcode,
   output logic               rsp_masked,
   output logic [63:0]        rsp_payload_length,
   output logic [31:0]        rsp_mask_key
);
   import wfhp_pkg::*;

   logic [7:0]  first_ff, first_in;
   logic        mask_ff, mask_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic        rsp_valid_ff;
   logic        rsp_fin_ff, rsp_rsv1_ff, rsp_rsv2_ff, rsp_rsv3_ff, rsp_masked_ff;
   logic [3:0]  rsp_opcode_ff;
   logic [63:0] rsp_len_ff;
   logic [31:0] rsp_key_ff;
   logic        out_free;
   logic        emit;
   logic [6:0]  code;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = pop_valid && (!pop_ent.last || out_free);
   assign emit     = pop && pop_ent.last;
   assign code     = pop_ent.data[6:0];

   always_comb begin
      first_in = first_ff;
      mask_in  = mask_ff;
      len_in   = len_ff;
      key_in   = key_ff;
      unique case (pop_ent.op)
         PH_FIRST: begin
            first_in = pop_ent.data;
         end
         PH_SECOND: begin
            mask_in = pop_ent.data[7];
            key_in  = '0;
            if (code == LEN_CODE_16 || code == LEN_CODE_64) begin
               len_in = '0;
            end else begin
               len_in = {57'd0, code};
            end
         end
         PH_EXTLEN: begin
            len_in = {len_ff[55:0], pop_ent.data};
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], pop_ent.data};
         end
         default: begin
            first_in = first_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         first_ff <= first_in;
         mask_ff  <= mask_in;
         len_ff   <= len_in;
         key_ff   <= key_in;
      end
      if (emit) begin
         rsp_fin_ff    <= first_in[7];
         rsp_rsv1_ff   <= first_in[6];
         rsp_rsv2_ff   <= first_in[5];
         rsp_rsv3_ff   <= first_in[4];
         rsp_opcode_ff <= first_in[3:0];
         rsp_masked_ff <= mask_in;
         rsp_len_ff    <= len_in;
         rsp_key_ff    <= mask_in ? key_in : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fin            = rsp_fin_ff;
   assign rsp_rsv1           = rsp_rsv1_ff;
   assign rsp_rsv2           = rsp_rsv2_ff;
   assign rsp_rsv3           = rsp_rsv3_ff;
   assign rsp_frame_opcode   = rsp_opcode_ff;
   assign rsp_masked         = rsp_masked_ff;
   assign rsp_payload_length = rsp_len_ff;
   assign rsp_mask_key       = rsp_key_ff;

endmodule

[hdl/websocket_frame_header_parser.sv]
// WebSocket frame header parser, top level: front end, word queue, back end.
// Depends on wfhp_pkg, wfhp_front, wfhp_queue and wfhp_back.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  data_byte[7:0], restart
//   rsp_      out        rsp_valid / rsp_stall  fin, rsv1..3, frame_opcode, masked,
//                                               payload_length[63:0], mask_key[31:0]
//
// One header word is taken per cycle while req_stall is low. With the queue empty and the
// output register free, the last word is queued, then rsp_valid is registered from it.
// Synchronous active-high reset returns the parser to the first header word and empties
// the queue and the output register. req_stall rises only when the queue holds
// QUEUE_DEPTH words: rsp_stall holds a result, the next header's last word waits at the
// queue head and further words pile up behind it.
module websocket_frame_header_parser #(
   parameter int QUEUE_DEPTH = wfhp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_fin,
   output logic        rsp_rsv1,
   output logic        rsp_rsv2,
   output logic        rsp_rsv3,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_masked,
   output logic [63:0] rsp_payload_length,
   output logic [31:0] rsp_mask_key
);
   import wfhp_pkg::*;

   logic     push_valid;
   qent_type push_ent;
   logic     push_full;
   logic     pop_valid;
   qent_type pop_ent;
   logic     pop;

   wfhp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_restart   (req_restart),
      .push_valid    (push_valid),
      .push_ent      (push_ent),
      .push_full     (push_full)
   );

   wfhp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ent   (push_ent),
      .push_full  (push_full),
      .pop_valid  (pop_valid),
      .pop_ent    (pop_ent),
      .pop        (pop)
   );

   wfhp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ent            (pop_ent),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fin            (rsp_fin),
      .rsp_rsv1           (rsp_rsv1),
      .rsp_rsv2           (rsp_rsv2),
      .rsp_rsv3           (rsp_rsv3),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_masked         (rsp_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_mask_key       (rsp_mask_key)
   );

endmodule
